/* hdl/complex_arithmetic_unit_defines.svh */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_defines: assertion macros
// Shared by the modules of the complex arithmetic unit that carry checks.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define CAU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Operation codes, status codes, CORDIC arctangent table, divider sizing.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MAG = 3'd4,
		OP_PHS = 3'd5,
		OP_NOP6 = 3'd6,
		OP_NOP7 = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2,
		ST_RSV = 2'd3
	} status_t;

	localparam int CordicMax = 24;
	localparam logic signed [31:0] PiQ16 = 32'sd205887;
	localparam logic [15:0] InvGainQ16 = 16'd39797;
	// dividend magnitude < 2^49, divisor <= 2^31
	localparam int NumW = 49;
	localparam int DenW = 32;

	// command passed from the front end through the queue
	typedef struct packed {
		op_t               op;
		logic              special;  // divide by zero or phase of zero
		logic signed [15:0] a_re;
		logic signed [15:0] a_im;
		logic signed [15:0] b_re;
		logic signed [15:0] b_im;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic [1:0]         status;
	} res_t;

	function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0: v = 32'sd51472;
			5'd1: v = 32'sd30386;
			5'd2: v = 32'sd16055;
			5'd3: v = 32'sd8150;
			5'd4: v = 32'sd4091;
			5'd5: v = 32'sd2047;
			5'd6: v = 32'sd1024;
			5'd7: v = 32'sd512;
			5'd8: v = 32'sd256;
			5'd9: v = 32'sd128;
			5'd10: v = 32'sd64;
			5'd11: v = 32'sd32;
			5'd12: v = 32'sd16;
			5'd13: v = 32'sd8;
			5'd14: v = 32'sd4;
			5'd15: v = 32'sd2;
			5'd16: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
		output logic s);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7fffffff;
			s = 1'b1;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
			s = 1'b1;
		end else begin
			r = v[31:0];
			s = 1'b0;
		end
		return r;
	endfunction

endpackage

/* hdl/cau_stream_if.sv */
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if: operand and result channels of the complex ALU
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface cau_in_if ();
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [15:0] a_re;
	logic signed [15:0] a_im;
	logic signed [15:0] b_re;
	logic signed [15:0] b_im;

	modport source (output valid, output op, output a_re, output a_im,
		output b_re, output b_im, input ready);
	modport sink (input valid, input op, input a_re, input a_im,
		input b_re, input b_im, output ready);
endinterface

interface cau_out_if ();
	logic               valid;
	logic               ready;
	logic signed [31:0] res_re;
	logic signed [31:0] res_im;
	logic [1:0]         status;

	modport source (output valid, output res_re, output res_im, output status,
		input ready);
	modport sink (input valid, input res_re, input res_im, input status,
		output ready);
endinterface

/* hdl/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front: input stage
// Registers accepted beats and flags the special cases of divide and phase.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           in_op,
	input  logic signed [15:0]   in_a_re,
	input  logic signed [15:0]   in_a_im,
	input  logic signed [15:0]   in_b_re,
	input  logic signed [15:0]   in_b_im,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cau_pkg::cmd_t        cmd
);
	import cau_pkg::*;

	logic  valid_q;
	cmd_t  cmd_q;
	logic  special;

	assign in_ready = !valid_q || cmd_ready;

	// classify: zero divisor, zero phase argument
	always_comb begin
		special = 1'b0;
		case (op_t'(in_op))
			OP_DIV: special = (in_b_re == 16'sd0) && (in_b_im == 16'sd0);
			OP_PHS: special = (in_a_re == 16'sd0) && (in_a_im == 16'sd0);
			default: special = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q.op      <= op_t'(in_op);
			cmd_q.special <= special;
			cmd_q.a_re    <= in_a_re;
			cmd_q.a_im    <= in_a_im;
			cmd_q.b_re    <= in_b_re;
			cmd_q.b_im    <= in_b_im;
		end
	end

	assign cmd_valid = valid_q;
	assign cmd       = cmd_q;
endmodule

/* hdl/cau_queue.sv */
// ----------------------------------------------------------------------------
// cau_queue: small command FIFO between front and back end
// Lets the front accept while the back stalls, and vice versa.
// ----------------------------------------------------------------------------
module cau_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  cau_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output cau_pkg::cmd_t rd_data
);
	import cau_pkg::*;
	`include "complex_arithmetic_unit_defines.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr_en, rd_en;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= inc(wp_q);
			if (rd_en) rp_q <= inc(rp_q);
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	`CAU_ASSERT(a_q_cnt, clk, arst_n, cnt_q <= (AW+1)'(DEPTH), "queue overfilled")
	`CAU_ASSERT_NEXT(a_q_fill, clk, arst_n, wr_en && !rd_en, cnt_q == $past(cnt_q) + 1'b1,
		"queue count lost a write")
	`CAU_ASSERT_NEXT(a_q_drain, clk, arst_n, rd_en && !wr_en, cnt_q == $past(cnt_q) - 1'b1,
		"queue count lost a read")
endmodule

/* hdl/cau_back.sv */
// ----------------------------------------------------------------------------
// cau_back: execution pipeline
// Fixed-length pipeline: products, prep, restoring divider (one quotient bit per
// stage, CORDIC steps alongside), then saturation and an output register.
// ----------------------------------------------------------------------------
module cau_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cau_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output cau_pkg::res_t res
);
	import cau_pkg::*;
	`include "complex_arithmetic_unit_defines.svh"

	localparam int NC = (CORDIC_STEPS > CordicMax) ? CordicMax : CORDIC_STEPS;
	localparam int QW = NumW;            // quotient bits, one per stage
	localparam int NS = (QW > NC) ? QW : NC;
	localparam int L  = NS + 2;          // stages: input register, prep, iterations

	// pipeline payload
	typedef struct packed {
		op_t                op;
		logic               special;
		logic signed [33:0] pre;    // add/sub/mul real, divide numerator real
		logic signed [33:0] pim;
		logic               nre;    // quotient sign
		logic               nim;
		logic [NumW-1:0]    rre;    // divider remainders
		logic [NumW-1:0]    rim;
		logic [NumW-1:0]    nmre;   // dividend magnitudes (shifted out MSB first)
		logic [NumW-1:0]    nmim;
		logic [DenW-1:0]    den;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [31:0] cz;
	} pl_t;

	logic stall;
	logic vld_s [1:L];
	pl_t  pl_s  [1:L];
	res_t res_q;
	logic rv_q;

	// the whole pipeline freezes while the output register waits
	assign stall     = rv_q && !res_ready;
	assign cmd_ready = !stall;

	// stage 0: products
	logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
	pl_t p0;
	always_comb begin
		p_rr = cmd.a_re * cmd.b_re;
		p_ii = cmd.a_im * cmd.b_im;
		p_ri = cmd.a_re * cmd.b_im;
		p_ir = cmd.a_im * cmd.b_re;
		p0 = '0;
		p0.op = cmd.op;
		p0.special = cmd.special;
		p0.cz = '0;
		case (cmd.op)
			OP_ADD: begin
				p0.pre = 34'(cmd.a_re + 17'sd0 + cmd.b_re) <<< 8;
				p0.pim = 34'(cmd.a_im + 17'sd0 + cmd.b_im) <<< 8;
			end
			OP_SUB: begin
				p0.pre = 34'(cmd.a_re - 17'sd0 - cmd.b_re) <<< 8;
				p0.pim = 34'(cmd.a_im - 17'sd0 - cmd.b_im) <<< 8;
			end
			OP_MUL, OP_DIV: begin
				p0.pre = (cmd.op == OP_MUL) ? 34'(p_rr) - 34'(p_ii) : 34'(p_rr) + 34'(p_ii);
				p0.pim = (cmd.op == OP_MUL) ? 34'(p_ir) + 34'(p_ri) : 34'(p_ir) - 34'(p_ri);
			end
			OP_MAG, OP_PHS: begin
				if (cmd.a_re < 0) begin
					p0.cx = -(34'(cmd.a_re) <<< 8);
					p0.cy = -(34'(cmd.a_im) <<< 8);
					p0.cz = (cmd.a_im >= 0) ? PiQ16 : -PiQ16;
				end else begin
					p0.cx = 34'(cmd.a_re) <<< 8;
					p0.cy = 34'(cmd.a_im) <<< 8;
				end
			end
			default: ;
		endcase
	end

	// stage 1: divisor and dividend magnitudes
	function automatic pl_t prep(input pl_t p, input logic signed [15:0] br,
		input logic signed [15:0] bi);
		pl_t r;
		logic signed [33:0] a;
		r = p;
		r.den = DenW'(br * br) + DenW'(bi * bi);
		a = p.pre;
		r.nre = a[33];
		r.nmre = NumW'(a[33] ? -a : a) << 16;
		a = p.pim;
		r.nim = a[33];
		r.nmim = NumW'(a[33] ? -a : a) << 16;
		r.rre = '0;
		r.rim = '0;
		return r;
	endfunction

	// one iteration stage: one quotient bit of each divide, one CORDIC step
	function automatic pl_t iter(input pl_t p, input int k);
		pl_t r;
		logic [NumW:0] t;
		logic signed [33:0] xs, ys;
		r = p;
		if (p.op == OP_DIV && k < QW) begin
			t = {p.rre, p.nmre[NumW-1]};
			r.nmre = {p.nmre[NumW-2:0], (t >= (NumW+1)'(p.den))};
			r.rre = (t >= (NumW+1)'(p.den)) ? NumW'(t - (NumW+1)'(p.den)) : NumW'(t);
			t = {p.rim, p.nmim[NumW-1]};
			r.nmim = {p.nmim[NumW-2:0], (t >= (NumW+1)'(p.den))};
			r.rim = (t >= (NumW+1)'(p.den)) ? NumW'(t - (NumW+1)'(p.den)) : NumW'(t);
		end
		if ((p.op == OP_MAG || p.op == OP_PHS) && k < NC) begin
			xs = p.cx >>> k;
			ys = p.cy >>> k;
			if (p.cy >= 0) begin
				r.cx = p.cx + ys;
				r.cy = p.cy - xs;
				r.cz = p.cz + atan_tab(5'(k));
			end else begin
				r.cx = p.cx - ys;
				r.cy = p.cy + xs;
				r.cz = p.cz - atan_tab(5'(k));
			end
		end
		return r;
	endfunction

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= L; i++) vld_s[i] <= 1'b0;
		end else if (!stall) begin
			vld_s[1] <= cmd_valid;
			for (int i = 2; i <= L; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	logic signed [15:0] cmd_b_re_s1, cmd_b_im_s1;
	always_ff @(posedge clk) begin
		if (!stall) begin
			cmd_b_re_s1 <= cmd.b_re;
			cmd_b_im_s1 <= cmd.b_im;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			pl_s[1] <= p0;
			pl_s[2] <= prep(pl_s[1], cmd_b_re_s1, cmd_b_im_s1);
			for (int k = 0; k < NS; k++) pl_s[k+3] <= iter(pl_s[k+2], k);
		end
	end

	// last stage mapped to the output
	logic signed [49:0] magp;
	logic signed [33:0] qre, qim;
	logic               s1, s2;
	res_t               fin;
	always_comb begin
		magp = 50'(pl_s[L].cx) * $signed({1'b0, InvGainQ16}) + 50'sd32768;
		qre  = pl_s[L].nre ? -34'(pl_s[L].nmre) : 34'(pl_s[L].nmre);
		qim  = pl_s[L].nim ? -34'(pl_s[L].nmim) : 34'(pl_s[L].nmim);
		s1 = 1'b0;
		s2 = 1'b0;
		fin = '0;
		case (pl_s[L].op)
			OP_ADD, OP_SUB: begin
				fin.res_re = pl_s[L].pre[31:0];
				fin.res_im = pl_s[L].pim[31:0];
			end
			OP_MUL: begin
				fin.res_re = sat34(pl_s[L].pre, s1);
				fin.res_im = sat34(pl_s[L].pim, s2);
			end
			OP_DIV: begin
				if (!pl_s[L].special) begin
					fin.res_re = (|pl_s[L].nmre[NumW-1:33]) ?
						(pl_s[L].nre ? 32'sh80000000 : 32'sh7fffffff) : sat34(qre, s1);
					fin.res_im = (|pl_s[L].nmim[NumW-1:33]) ?
						(pl_s[L].nim ? 32'sh80000000 : 32'sh7fffffff) : sat34(qim, s2);
					s1 = s1 | (|pl_s[L].nmre[NumW-1:33]);
					s2 = s2 | (|pl_s[L].nmim[NumW-1:33]);
				end
			end
			OP_MAG: fin.res_re = sat34(34'(magp >>> 16), s1);
			OP_PHS: if (!pl_s[L].special) fin.res_re = pl_s[L].cz;
			default: ;
		endcase
		fin.status = pl_s[L].special ? ST_DZ : ((s1 || s2) ? ST_SAT : ST_OK);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q <= 1'b0;
		else if (!stall) rv_q <= vld_s[L];
	end
	always_ff @(posedge clk) begin
		if (!stall) res_q <= fin;
	end
	assign res_valid = rv_q;
	assign res       = res_q;

	`CAU_ASSERT(a_b_status, clk, arst_n, !res_valid || res.status != ST_RSV,
		"reserved status code issued")
	`CAU_ASSERT_NEXT(a_b_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res),
		"stalled result changed")
	`CAU_ASSERT(a_b_iszero, clk, arst_n, !res_valid || res.status != ST_DZ ||
		(res.res_re == 32'sd0 && res.res_im == 32'sd0), "special case result not zero")
endmodule

/* hdl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU on Q8.8 operands
// Usage:
//   Input channel in_ch carries op, a_re, a_im, b_re, b_im; output channel
//   out_ch carries res_re, res_im (Q16.16) and status. One result per beat,
//   in order.
//   Throughput: one beat per cycle while the receiver takes results. The
//   front registers each beat and flags zero divisors and zero phase
//   arguments; a four-entry queue feeds the execution pipeline.
//   Path, the same for every op: front register, queue, input register
//   and prep stage, 49 divider stages (one quotient bit each, the CORDIC
//   steps run alongside) and the output register.
//   Reset clears all valid flags; the output is empty after reset.
//   When the receiver stalls the output register holds, the pipeline freezes,
//   the queue fills, and in_ch.ready drops once it is full and the front holds a beat.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input logic    clk,
	input logic    arst_n,
	cau_in_if.sink   in_ch,
	cau_out_if.source out_ch
);
	import cau_pkg::*;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;
	logic rv;
	res_t rs;

	cau_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_op(in_ch.op), .in_a_re(in_ch.a_re), .in_a_im(in_ch.a_im),
		.in_b_re(in_ch.b_re), .in_b_im(in_ch.b_im),
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	cau_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
	);

	cau_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n,
		.cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.res_valid(rv), .res_ready(out_ch.ready), .res(rs)
	);

	assign out_ch.valid  = rv;
	assign out_ch.res_re = rs.res_re;
	assign out_ch.res_im = rs.res_im;
	assign out_ch.status = rs.status;
endmodule

/* tb/cau_if.sv */
// ----------------------------------------------------------------------------
// cau_if: channels seen by the bench
// The bench drives and samples cau_in_if and cau_out_if from the RTL folder,
// so both sides share one definition of the operand and result channels.
// ----------------------------------------------------------------------------

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex arithmetic unit
// Walks a table of corner-case operand beats, then random bursts, and checks
// every result beat in order against the table's answer or a bit-true model.
// ----------------------------------------------------------------------------
module tb_top;
	import cau_pkg::*;

	localparam int Steps = 16;
	localparam int NumRandom = 1600;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		status_t            st;
	} answer_t;

	typedef struct {
		op_t                op;
		logic signed [15:0] ar, ai, br, bi;
		bit                 known;
		answer_t            ans;
	} row_t;

	logic clk;
	logic arst_n;
	cau_in_if  in_ch ();
	cau_out_if out_ch ();

	complex_arithmetic_unit #(.CORDIC_STEPS(Steps)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	answer_t answer_q[$];
	int      n_errors = 0;
	int      n_sent = 0;
	bit      stim_done = 0;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// saturate to the signed 32-bit range
	function automatic longint clip32(input longint v, inout bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint atan_step(input int i);
		longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (i < 17) ? t[i] : 0;
	endfunction

	// bit-true complex arithmetic: one answer per operand beat
	function automatic answer_t complex_result(input op_t op,
		input logic signed [15:0] ar16, ai16, br16, bi16);
		longint ar, ai, br, bi, re, im, den, x, y, z, nx, ny;
		bit hit;
		answer_t r;
		ar = ar16; ai = ai16; br = br16; bi = bi16;
		re = 0; im = 0; hit = 0;
		r.st = ST_OK;
		case (op)
			OP_ADD: begin
				re = (ar + br) * 256;
				im = (ai + bi) * 256;
			end
			OP_SUB: begin
				re = (ar - br) * 256;
				im = (ai - bi) * 256;
			end
			OP_MUL: begin
				re = clip32(ar * br - ai * bi, hit);
				im = clip32(ai * br + ar * bi, hit);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.st = ST_DZ;
				end else begin
					re = clip32(((ar * br + ai * bi) * 65536) / den, hit);
					im = clip32(((ai * br - ar * bi) * 65536) / den, hit);
				end
			end
			OP_MAG, OP_PHS: begin
				if (op == OP_PHS && ar == 0 && ai == 0) begin
					r.st = ST_DZ;
				end else begin
					// vectoring CORDIC, left half-plane folded first
					x = ar * 256; y = ai * 256; z = 0;
					if (x < 0) begin
						x = -x;
						y = -y;
						z = (ai >= 0) ? 64'sd205887 : -64'sd205887;
					end
					for (int i = 0; i < ((Steps > 24) ? 24 : Steps); i++) begin
						if (y >= 0) begin
							nx = x + (y >>> i);
							ny = y - (x >>> i);
							z = z + atan_step(i);
						end else begin
							nx = x - (y >>> i);
							ny = y + (x >>> i);
							z = z - atan_step(i);
						end
						x = nx;
						y = ny;
					end
					if (op == OP_MAG)
						re = clip32((x * 39797 + 32768) >>> 16, hit);
					else
						re = clip32(z, hit);
				end
			end
			default: ;
		endcase
		if (hit && r.st == ST_OK)
			r.st = ST_SAT;
		r.re = re[31:0];
		r.im = im[31:0];
		return r;
	endfunction

	function automatic row_t mk(input op_t op, input int ar, ai, br, bi,
		input bit known = 0, input int re = 0, input int im = 0,
		input status_t st = ST_OK);
		row_t r;
		r.op = op;
		r.ar = 16'(ar); r.ai = 16'(ai); r.br = 16'(br); r.bi = 16'(bi);
		r.known = known;
		r.ans.re = re; r.ans.im = im; r.ans.st = st;
		return r;
	endfunction

	// offer one beat and wait for it to be taken
	task automatic send_beat(input row_t r);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.op <= r.op;
		in_ch.a_re <= r.ar;
		in_ch.a_im <= r.ai;
		in_ch.b_re <= r.br;
		in_ch.b_im <= r.bi;
		forever begin
			@(posedge clk);
			if (in_ch.ready)
				break;
		end
		answer_q.push_back(r.known ? r.ans
			: complex_result(r.op, r.ar, r.ai, r.br, r.bi));
		n_sent++;
	endtask

	task automatic idle_for(input int n);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_operand();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 1023) - 512);
			1: return 16'($urandom_range(0, 7) - 4);
			default: return 16'($urandom());
		endcase
	endfunction

	// sender: directed table, then random bursts
	initial begin
		row_t table_rows[$];
		row_t r;
		int burst;
		in_ch.valid = 1'b0;
		in_ch.op = OP_ADD;
		in_ch.a_re = '0; in_ch.a_im = '0; in_ch.b_re = '0; in_ch.b_im = '0;

		table_rows = '{
			mk(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK),
			mk(OP_ADD, 32767, 32767, 32767, 32767, 1, 16776704, 16776704, ST_OK),
			mk(OP_ADD, -32768, -32768, -32768, -32768, 1, -16777216, -16777216),
			mk(OP_SUB, 32767, -32768, -32768, 32767, 1, 16776960, -16776960),
			mk(OP_SUB, 256, 512, 128, -256),
			mk(OP_MUL, -32768, -32768, -32768, -32768, 1, 0, 32'h7fffffff, ST_SAT),
			mk(OP_MUL, -32768, 0, -32768, 0, 1, 32'h40000000, 0, ST_OK),
			mk(OP_MUL, 32767, -32768, 32767, 32767),
			mk(OP_MUL, 300, -200, 700, 50),
			mk(OP_DIV, 1234, -999, 0, 0, 1, 0, 0, ST_DZ),
			mk(OP_DIV, 32767, 32767, 1, 0),
			mk(OP_DIV, -32768, -32768, 0, -1),
			mk(OP_DIV, 256, 0, 256, 0, 1, 65536, 0, ST_OK),
			mk(OP_DIV, 100, 200, -300, 400),
			mk(OP_MAG, 0, 0, 5, 5, 1, 0, 0, ST_OK),
			mk(OP_MAG, -32768, -32768, 0, 0),
			mk(OP_MAG, 32767, 0, 0, 0),
			mk(OP_MAG, 3, -4, 0, 0),
			mk(OP_PHS, 0, 0, 1, 1, 1, 0, 0, ST_DZ),
			mk(OP_PHS, -256, 0, 0, 0),
			mk(OP_PHS, -256, -1, 0, 0),
			mk(OP_PHS, 0, -32768, 0, 0),
			mk(OP_PHS, 32767, 32767, 0, 0),
			mk(OP_NOP6, 32767, -1, 77, 88, 1, 0, 0, ST_OK),
			mk(OP_NOP7, -32768, 5, -1, 32767, 1, 0, 0, ST_OK)
		};

		wait (arst_n === 1'b1);
		foreach (table_rows[i])
			send_beat(table_rows[i]);

		// random bursts with random gaps
		for (int k = 0; k < NumRandom; ) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && k < NumRandom; j++, k++) begin
				r.op = op_t'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
					: $urandom_range(0, 5));
				r.ar = rand_operand(); r.ai = rand_operand();
				r.br = rand_operand(); r.bi = rand_operand();
				if ($urandom_range(0, 19) == 0) begin
					r.br = 0;
					r.bi = 0;
				end
				r.known = 0;
				send_beat(r);
				// let the pipeline drain once, mid-run
				if (k == 900) begin
					idle_for(0);
					wait (answer_q.size() == 0);
				end
			end
			if ($urandom_range(0, 2) != 0)
				idle_for($urandom_range(0, 10));
		end
		idle_for(0);
		stim_done = 1;
	end

	// receiver: stall pattern switches among four modes, one long hold-off
	initial begin
		int cyc;
		int mode;
		bit held;
		cyc = 0;
		mode = 0;
		held = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (!held && n_sent >= 400) begin
				held = 1;
				out_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 1) == 1);
				2: out_ch.ready <= ($urandom_range(0, 9) != 0);
				default: out_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (answer_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: re=%0d im=%0d st=%0d",
					$time, out_ch.res_re, out_ch.res_im, out_ch.status);
				n_errors++;
			end else begin
				e = answer_q.pop_front();
				if (out_ch.res_re !== e.re) begin
					$display("%0t: res_re expected %0d actual %0d", $time, e.re,
						out_ch.res_re);
					n_errors++;
				end
				if (out_ch.res_im !== e.im) begin
					$display("%0t: res_im expected %0d actual %0d", $time, e.im,
						out_ch.res_im);
					n_errors++;
				end
				if (out_ch.status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st,
						out_ch.status);
					n_errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (answer_q.size() == 0);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && answer_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("%0t: timeout, %0d results outstanding", $time, answer_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_stream_if.sv
hdl/cau_front.sv
hdl/cau_queue.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
tb/cau_if.sv
tb/tb_top.sv
